[rtl/core/ucd_pkg.sv]
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

    localparam int unsigned CP_W        = 21;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] CP_REPLACEMENT = CP_W'(8'h3F);  // '?'
    localparam logic [CP_W-1:0] CP_MAX         = CP_W'(21'h10FFFF);
    localparam logic [CP_W-1:0] CP_SURR_LO     = CP_W'(16'hD800);
    localparam logic [CP_W-1:0] CP_SURR_HI     = CP_W'(16'hDFFF);
    localparam logic [CP_W-1:0] CP_MIN_2BYTE   = CP_W'(8'h80);
    localparam logic [CP_W-1:0] CP_MIN_3BYTE   = CP_W'(12'h800);
    localparam logic [CP_W-1:0] CP_MIN_4BYTE   = CP_W'(17'h10000);

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // Work for the back end: flush_cnt '?' results, then an optional final one
    typedef struct packed {
        logic [1:0]      flush_cnt;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
        logic            final_repl;
        logic            final_eot;
    } t_job;

endpackage : ucd_pkg

`default_nettype wire

[rtl/core/ucd_front.sv]
// ----------------------------------------------------------------------------
// ucd_front
// Takes text bytes, tracks the pending sequence and turns each byte that
// ends, breaks or stands outside a sequence into one job for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucd_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [ucd_pkg::BYTE_W-1:0] i_data_byte,
    output logic                           o_ready,
    input  wire logic                      i_push_ready,
    output logic                           o_push,
    output ucd_pkg::t_job                  o_job
);
    import ucd_pkg::*;

    logic [2:0]      r_exp_len, n_exp_len;
    logic [2:0]      r_rcvd,    n_rcvd;
    logic [CP_W-1:0] r_partial, n_partial;

    t_job            job;
    logic            accept;
    logic            is_cont;
    logic            do_lead;
    logic [2:0]      rcvd_inc;
    logic [CP_W-1:0] value;
    logic [CP_W-1:0] minimum;
    logic            bad;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && o_ready;
    assign is_cont = (i_data_byte[7:6] == 2'b10);
    assign rcvd_inc = r_rcvd + 3'd1;
    assign value    = {r_partial[CP_W-7:0], i_data_byte[5:0]};

    always_comb begin
        unique case (r_exp_len)
            LEN_2:   minimum = CP_MIN_2BYTE;
            LEN_3:   minimum = CP_MIN_3BYTE;
            default: minimum = CP_MIN_4BYTE;
        endcase
        bad = (value < minimum) || (value > CP_MAX)
           || ((value >= CP_SURR_LO) && (value <= CP_SURR_HI));
    end

    always_comb begin
        job       = '0;
        n_exp_len = r_exp_len;
        n_rcvd    = r_rcvd;
        n_partial = r_partial;
        do_lead   = 1'b0;

        if (r_exp_len != LEN_NONE) begin
            if (is_cont) begin
                if (rcvd_inc >= r_exp_len) begin
                    job.has_final  = 1'b1;
                    job.final_cp   = bad ? CP_REPLACEMENT : value;
                    job.final_repl = bad;
                    n_exp_len      = LEN_NONE;
                    n_rcvd         = '0;
                    n_partial      = '0;
                end else begin
                    n_rcvd    = rcvd_inc;
                    n_partial = value;
                end
            end else begin
                // broken sequence: one '?' per byte taken, then re-read as lead
                job.flush_cnt = (r_rcvd > 3'd3) ? 2'd3 : r_rcvd[1:0];
                n_exp_len     = LEN_NONE;
                n_rcvd        = '0;
                n_partial     = '0;
                do_lead       = 1'b1;
            end
        end else if (is_cont) begin
            job.has_final  = 1'b1;
            job.final_cp   = CP_REPLACEMENT;
            job.final_repl = 1'b1;
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            priority if (i_data_byte == '0) begin
                job.has_final = 1'b1;
                job.final_eot = 1'b1;
            end else if (!i_data_byte[7]) begin
                job.has_final = 1'b1;
                job.final_cp  = CP_W'(i_data_byte);
            end else if (i_data_byte[7:5] == 3'b110) begin
                n_exp_len = LEN_2;
                n_rcvd    = 3'd1;
                n_partial = CP_W'(i_data_byte[4:0]);
            end else if (i_data_byte[7:4] == 4'b1110) begin
                n_exp_len = LEN_3;
                n_rcvd    = 3'd1;
                n_partial = CP_W'(i_data_byte[3:0]);
            end else if (i_data_byte[7:3] == 5'b11110) begin
                n_exp_len = LEN_4;
                n_rcvd    = 3'd1;
                n_partial = CP_W'(i_data_byte[2:0]);
            end else begin
                job.has_final  = 1'b1;
                job.final_cp   = CP_REPLACEMENT;
                job.final_repl = 1'b1;
            end
        end
    end

    // bytes that only extend a sequence need no queue slot
    assign o_push = accept && (job.has_final || (job.flush_cnt != 2'd0));
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= LEN_NONE;
            r_rcvd    <= '0;
            r_partial <= '0;
        end else if (accept) begin
            r_exp_len <= n_exp_len;
            r_rcvd    <= n_rcvd;
            r_partial <= n_partial;
        end
    end

`ifndef SYNTHESIS
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_len == LEN_NONE) |-> (r_rcvd == 3'd0 && r_partial == '0))
        else $error("idle front holds stale sequence state");

    a_pending_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_len != LEN_NONE) |-> (r_rcvd != 3'd0 && r_rcvd < r_exp_len))
        else $error("received count out of range for pending sequence");

    a_flush_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_len == LEN_NONE) |-> (job.flush_cnt == 2'd0))
        else $error("flush requested with no sequence pending");
`endif

endmodule : ucd_front

`default_nettype wire

[rtl/core/ucd_queue.sv]
// ----------------------------------------------------------------------------
// ucd_queue
// Short register queue of jobs between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ucd_pkg::t_job i_job,
    output logic               o_push_ready,
    output logic               o_head_valid,
    output ucd_pkg::t_job      o_head,
    input  wire logic          i_pop
);
    import ucd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              do_push, do_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_push && o_push_ready;
    assign do_pop  = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule : ucd_queue

`default_nettype wire

[rtl/core/ucd_back.sv]
// ----------------------------------------------------------------------------
// ucd_back
// Expands the job at the queue head into result items, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucd_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_head_valid,
    input  wire ucd_pkg::t_job            i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [ucd_pkg::CP_W-1:0]      o_code_point,
    output logic                          o_was_replaced,
    output logic                          o_end_of_text,
    output logic                          o_last_of_run
);
    import ucd_pkg::*;

    logic [1:0]      r_idx, n_idx;
    logic            r_out_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_repl, r_eot, r_last;

    logic            take;
    logic            in_flush;
    logic            is_last;
    logic [CP_W-1:0] cp;
    logic            repl, eot;

    assign take     = i_head_valid && (!r_out_valid || i_ready);
    assign in_flush = (r_idx < i_head.flush_cnt);
    assign is_last  = in_flush ? ((r_idx + 2'd1 == i_head.flush_cnt) && !i_head.has_final)
                               : 1'b1;

    always_comb begin
        if (in_flush) begin
            cp   = CP_REPLACEMENT;
            repl = 1'b1;
            eot  = 1'b0;
        end else begin
            cp   = i_head.final_cp;
            repl = i_head.final_repl;
            eot  = i_head.final_eot;
        end
        n_idx = r_idx;
        if (take) begin
            n_idx = is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_pop = take && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cp   <= cp;
            r_repl <= repl;
            r_eot  <= eot;
            r_last <= is_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_code_point   = r_cp;
    assign o_was_replaced = r_repl;
    assign o_end_of_text  = r_eot;
    assign o_last_of_run  = r_last;

`ifndef SYNTHESIS
    a_eot_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eot) |-> (r_last && r_cp == '0 && !r_repl))
        else $error("end marker item malformed");

    a_repl_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_repl) |-> (r_cp == CP_REPLACEMENT && !r_eot))
        else $error("replaced item without replacement code point");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx <= i_head.flush_cnt))
        else $error("result index ran past flush count");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_idx == 2'd0))
        else $error("result index not cleared with empty queue");
`endif

endmodule : ucd_back

`default_nettype wire

[rtl/core/utf8_codepoint_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// UTF-8 byte stream to Unicode code point decoder with malformed-input
// replacement and end-of-text marker.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while the job queue has room. Bytes that
// complete or break a sequence produce between one and four items, and
// the input side keeps taking bytes while the output side works through
// them, until the two-entry job queue fills. Continuation bytes that only
// extend a sequence produce nothing and never use the queue. A byte's job
// is written into the queue when the byte is taken; the result sequencer
// then loads each of its items into the output register whenever that
// register is free or being read. Malformed input comes out as '?' with
// o_was_replaced set; a zero byte flushes any pending sequence and ends
// with an item carrying o_end_of_text. o_last_of_run marks the final item
// of each byte.
`timescale 1ns / 1ps
`default_nettype none

module utf8_codepoint_decoder (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [ucd_pkg::BYTE_W-1:0] i_data_byte,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [ucd_pkg::CP_W-1:0]       o_code_point,
    output logic                           o_was_replaced,
    output logic                           o_end_of_text,
    output logic                           o_last_of_run
);
    import ucd_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push, push_ready;
    logic head_valid, pop;

    ucd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .o_ready      (o_ready),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_job        (push_job)
    );

    ucd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head       (head_job),
        .i_pop        (pop)
    );

    ucd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head_job),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_point   (o_code_point),
        .o_was_replaced (o_was_replaced),
        .o_end_of_text  (o_end_of_text),
        .o_last_of_run  (o_last_of_run)
    );

endmodule : utf8_codepoint_decoder

`default_nettype wire
